/* rtl/core/look_elevator_car_controller_core_macros.svh */
// ----------------------------------------------------------------------------
// elevator car controller assertion macros
// shared concurrent assertion forms for the car controller rtl
// ----------------------------------------------------------------------------
`ifndef LOOK_ELEVATOR_CAR_CONTROLLER_CORE_MACROS_SVH
`define LOOK_ELEVATOR_CAR_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define LECC_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define LECC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lecc_pkg.sv */
// ----------------------------------------------------------------------------
// elevator car controller package
// widths, codes, car state struct and heading selection shared by the rtl
// ----------------------------------------------------------------------------
package lecc_pkg;

    localparam int NUM_FLOORS = 64;
    localparam int FLOOR_W    = 6;
    localparam int FUNC_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 16;

    // highest floor a car can reach, bounded by the floor field
    localparam int TOP_CAP_I = (NUM_FLOORS - 1 > (1 << FLOOR_W) - 1) ?
                               (1 << FLOOR_W) - 1 : NUM_FLOORS - 1;
    localparam logic [FLOOR_W-1:0] TOP_CAP       = FLOOR_W'(TOP_CAP_I);
    localparam logic [FLOOR_W-1:0] MIN_FLOOR_RST = '0;
    localparam logic [FLOOR_W-1:0] MAX_FLOOR_RST = FLOOR_W'(63);

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FLOOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FLOOR = 1'b1;

    typedef logic [NUM_FLOORS-1:0] stop_map_t;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_UP    = 3'd1,
        MODE_DOWN  = 3'd2,
        MODE_DOOR  = 3'd3,
        MODE_EMERG = 3'd4,
        MODE_OOS   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        HEAD_NONE = 2'd0,
        HEAD_UP   = 2'd1,
        HEAD_DOWN = 2'd2
    } head_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD_STOP  = 3'd0,
        FUNC_MOVE_TICK = 3'd1,
        FUNC_OPEN_DOOR = 3'd2,
        FUNC_CLOSE     = 3'd3,
        FUNC_EMERGENCY = 3'd4,
        FUNC_OOS       = 3'd5,
        FUNC_AVAILABLE = 3'd6
    } func_t;

    typedef struct packed {
        logic [FLOOR_W-1:0] floor;
        mode_t              mode;
        head_t              head;
        stop_map_t          up_map;
        stop_map_t          dn_map;
    } car_state_t;

    typedef struct packed {
        mode_t mode;
        head_t head;
    } pick_t;

    // look rule: keep heading while stops lie that way, else turn, else rest
    function automatic pick_t pick_heading(head_t h, logic up_any, logic dn_any);
        pick_t p;
        p.mode = MODE_IDLE;
        p.head = HEAD_NONE;
        case (h)
            HEAD_UP: begin
                if (up_any) begin
                    p.mode = MODE_UP;   p.head = HEAD_UP;
                end else if (dn_any) begin
                    p.mode = MODE_DOWN; p.head = HEAD_DOWN;
                end
            end
            HEAD_DOWN: begin
                if (dn_any) begin
                    p.mode = MODE_DOWN; p.head = HEAD_DOWN;
                end else if (up_any) begin
                    p.mode = MODE_UP;   p.head = HEAD_UP;
                end
            end
            default: begin
                if (up_any) begin
                    p.mode = MODE_UP;   p.head = HEAD_UP;
                end else if (dn_any) begin
                    p.mode = MODE_DOWN; p.head = HEAD_DOWN;
                end
            end
        endcase
        return p;
    endfunction

endpackage

/* rtl/core/lecc_step.sv */
// ----------------------------------------------------------------------------
// elevator car command step
// next car state and status flags for one command against the current state
// ----------------------------------------------------------------------------
module lecc_step
    import lecc_pkg::*;
(
    input  car_state_t         st,
    input  logic [FUNC_W-1:0]  func,
    input  logic [FLOOR_W-1:0] req_floor,
    input  logic [FLOOR_W-1:0] min_floor,
    input  logic [FLOOR_W-1:0] max_floor,
    output car_state_t         nst,
    output logic               arrived,
    output logic               range_err
);

    logic               dis;
    logic               up_any;
    logic               dn_any;
    pick_t              pick_a;
    head_t              h_eff;
    logic [FLOOR_W-1:0] top_lim;
    logic               blocked;
    logic [FLOOR_W-1:0] new_floor;
    stop_map_t          mask_new;
    logic               hit_u;
    logic               hit_d;
    stop_map_t          up_clr;
    stop_map_t          dn_clr;
    pick_t              pick_c;
    stop_map_t          mask_req;
    logic               out_range;
    logic               go_up;
    pick_t              pick_d;

    always_comb begin
        dis    = (st.mode == MODE_EMERG) || (st.mode == MODE_OOS);
        up_any = |st.up_map;
        dn_any = |st.dn_map;
        pick_a = pick_heading(st.head, up_any, dn_any);
        h_eff  = (st.head == HEAD_NONE) ? pick_a.head : st.head;

        // move tick
        top_lim   = (max_floor < TOP_CAP) ? max_floor : TOP_CAP;
        blocked   = (h_eff == HEAD_UP) ? (st.floor >= top_lim) : (st.floor <= min_floor);
        new_floor = (h_eff == HEAD_UP) ? st.floor + FLOOR_W'(1) : st.floor - FLOOR_W'(1);
        mask_new  = stop_map_t'(1) << new_floor;
        hit_u     = |(st.up_map & mask_new);
        hit_d     = |(st.dn_map & mask_new);
        up_clr    = (h_eff == HEAD_UP && hit_u) ? (st.up_map & ~mask_new) : st.up_map;
        dn_clr    = (h_eff == HEAD_DOWN && hit_d) ? (st.dn_map & ~mask_new) : st.dn_map;
        pick_c    = pick_heading(h_eff, |up_clr, |dn_clr);

        // add stop
        mask_req  = stop_map_t'(1) << req_floor;
        out_range = (req_floor < min_floor) || (req_floor > max_floor) || (req_floor > TOP_CAP);
        go_up     = (st.head == HEAD_DOWN) ? !(req_floor < st.floor) : (req_floor > st.floor);
        pick_d    = pick_heading(st.head, up_any | go_up, dn_any | !go_up);

        nst       = st;
        arrived   = 1'b0;
        range_err = 1'b0;

        case (func)
            FUNC_ADD_STOP: begin
                if (out_range) begin
                    range_err = 1'b1;
                end else if (!dis) begin
                    if (req_floor == st.floor) begin
                        nst.mode = MODE_DOOR;
                    end else begin
                        if (go_up) begin
                            nst.up_map = st.up_map | mask_req;
                        end else begin
                            nst.dn_map = st.dn_map | mask_req;
                        end
                        nst.mode = pick_d.mode;
                        nst.head = pick_d.head;
                    end
                end
            end
            FUNC_MOVE_TICK: begin
                if (!dis && st.mode != MODE_DOOR) begin
                    if (h_eff == HEAD_NONE || blocked) begin
                        nst.mode = pick_a.mode;
                        nst.head = pick_a.head;
                    end else begin
                        nst.floor = new_floor;
                        nst.head  = h_eff;
                        nst.mode  = (h_eff == HEAD_UP) ? MODE_UP : MODE_DOWN;
                        if (hit_u || hit_d) begin
                            arrived    = 1'b1;
                            nst.up_map = up_clr;
                            nst.dn_map = dn_clr;
                            nst.mode   = pick_c.mode;
                            nst.head   = pick_c.head;
                        end
                    end
                end
            end
            FUNC_OPEN_DOOR: begin
                if (!dis) begin
                    nst.mode = MODE_DOOR;
                end
            end
            FUNC_CLOSE: begin
                if (st.mode == MODE_DOOR) begin
                    nst.mode = pick_a.mode;
                    nst.head = pick_a.head;
                end
            end
            FUNC_EMERGENCY, FUNC_OOS: begin
                nst.mode   = (func == FUNC_EMERGENCY) ? MODE_EMERG : MODE_OOS;
                nst.head   = HEAD_NONE;
                nst.up_map = '0;
                nst.dn_map = '0;
            end
            FUNC_AVAILABLE: begin
                if (dis) begin
                    nst.mode = MODE_IDLE;
                    nst.head = HEAD_NONE;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/core/look_elevator_car_controller_core.sv */
// a command word's status word reaches m_tdata through the input reg, which loads as the word is taken,
// and then the result reg, which loads once the result slot is free
// throughput: one command word per cycle while the result is not stalled, set by the combinational command step logic
// a stalled result holds in the result reg while one more command waits in the input reg
// reset (aresetn low, synchronous): stop maps clear, car at floor 0, idle, no heading,
// min_floor 0, max_floor 63, both channels empty
// ----------------------------------------------------------------------------
// look elevator car controller core
// one car under look scheduling: command stream in, car status stream out
// ----------------------------------------------------------------------------
`include "look_elevator_car_controller_core_macros.svh"

module look_elevator_car_controller_core
    import lecc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // command words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // [5:0] floor, [7:6] zero
    input  logic [FUNC_W-1:0]    s_tuser,   // [2:0] func

    // status words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // [0] arrived, [6:1] current_floor,
                                            // [9:7] car_state, [11:10] travel_direction,
                                            // [12] available, [13] range_error, [15:14] zero

    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FLOOR_W-1:0]   cfg_data
);

    // input stage
    logic               in_valid_reg,  in_valid_next;
    logic [FUNC_W-1:0]  in_func_reg,   in_func_next;
    logic [FLOOR_W-1:0] in_floor_reg,  in_floor_next;

    // car state and served range
    car_state_t         st_reg,        st_next;
    logic [FLOOR_W-1:0] min_floor_reg, min_floor_next;
    logic [FLOOR_W-1:0] max_floor_reg, max_floor_next;

    // result stage
    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg,  out_data_next;

    // step results
    car_state_t step_nst;
    logic       step_arrived;
    logic       step_range_err;
    logic       step_avail;

    logic advance;
    logic load_out;
    logic take_in;

    lecc_step u_step (
        .st        (st_reg),
        .func      (in_func_reg),
        .req_floor (in_floor_reg),
        .min_floor (min_floor_reg),
        .max_floor (max_floor_reg),
        .nst       (step_nst),
        .arrived   (step_arrived),
        .range_err (step_range_err)
    );

    // result slot frees when empty or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign load_out = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign take_in  = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign step_avail = !(step_nst.mode == MODE_EMERG || step_nst.mode == MODE_OOS);

    always_comb begin
        in_valid_next = in_valid_reg;
        in_func_next  = in_func_reg;
        in_floor_next = in_floor_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        if (take_in) begin
            in_func_next  = s_tuser;
            in_floor_next = s_tdata[FLOOR_W-1:0];
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
        end
        if (load_out) begin
            out_data_next = {2'b00, step_range_err, step_avail, step_nst.head,
                             step_nst.mode, step_nst.floor, step_arrived};
        end

        st_next        = st_reg;
        min_floor_next = min_floor_reg;
        max_floor_next = max_floor_reg;
        if (load_out) begin
            st_next = step_nst;
        end
        // the user must make register writes only while idle, not enforced by the block; min_floor also places the car
        if (cfg_valid) begin
            case (cfg_index)
                CFG_MIN_FLOOR: begin
                    min_floor_next = cfg_data;
                    st_next.floor  = cfg_data;
                end
                CFG_MAX_FLOOR: begin
                    max_floor_next = cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg.floor  <= MIN_FLOOR_RST;
            st_reg.mode   <= MODE_IDLE;
            st_reg.head   <= HEAD_NONE;
            st_reg.up_map <= '0;
            st_reg.dn_map <= '0;
            min_floor_reg <= MIN_FLOOR_RST;
            max_floor_reg <= MAX_FLOOR_RST;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            st_reg        <= st_next;
            min_floor_reg <= min_floor_next;
            max_floor_reg <= max_floor_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        in_func_reg  <= in_func_next;
        in_floor_reg <= in_floor_next;
        out_data_reg <= out_data_next;
    end

    // a shut-down car holds no heading and no stops
    `LECC_ASSERT_IMPLY(a_disabled_empty, aclk, aresetn,
        (st_reg.mode == MODE_EMERG || st_reg.mode == MODE_OOS),
        (st_reg.head == HEAD_NONE && st_reg.up_map == '0 && st_reg.dn_map == '0),
        "disabled car keeps stops or heading")

    // moving modes agree with heading
    `LECC_ASSERT_IMPLY(a_mode_head, aclk, aresetn,
        (st_reg.mode == MODE_UP || st_reg.mode == MODE_DOWN),
        ((st_reg.mode == MODE_UP && st_reg.head == HEAD_UP) ||
         (st_reg.mode == MODE_DOWN && st_reg.head == HEAD_DOWN)),
        "moving mode disagrees with heading")

    // a rejected stop leaves the car untouched
    `LECC_ASSERT_NEXT(a_range_err_hold, aclk, aresetn,
        (load_out && step_range_err && !cfg_valid),
        (st_reg == $past(st_reg)),
        "range error changed car state")

endmodule
